// ===== hw/rtl/gse_pkg.sv =====
package gse_pkg;

	localparam int CellW  = 16;
	localparam int DimW   = 9;
	localparam int CostW  = 16;
	localparam int NbrN   = 8;
	localparam int MapDepth = 65536;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_EXPAND = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		CFG_WIDTH    = 3'd0,
		CFG_HEIGHT   = 3'd1,
		CFG_STRAIGHT = 3'd2,
		CFG_DIAG     = 3'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_CALC,
		ST_READ,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [CellW-1:0] cell_id;
		logic             passable;
	} item_t;

	typedef struct packed {
		logic [DimW-1:0]  width;
		logic [DimW-1:0]  height;
		logic [CostW-1:0] straight_cost;
		logic [CostW-1:0] diag_cost;
	} cfg_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_stat_t;

endpackage

// ===== hw/rtl/gse_front.sv =====
module gse_front
	import gse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  item_t      in_item,
	output logic       q_valid,
	output item_t      q_item,
	input  back_stat_t stat
);

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2) && !stat.clearing;
	assign push     = in_valid && in_ready;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (stat.pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(stat.pop);
		end
	end

endmodule

// ===== hw/rtl/gse_div.sv =====
module gse_div
	import gse_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CellW-1:0] dividend,
	input  logic [DimW-1:0]  divisor,
	output logic             done,
	output logic [CellW-1:0] quo,
	output logic [DimW-1:0]  rem
);

	logic [CellW-1:0] quo_q;
	logic [DimW-1:0]  rem_q;
	logic [DimW-1:0]  dvs_q;
	logic [4:0]       cnt_q;
	logic             done_q;
	logic [DimW:0]    trial;
	logic             fits;

	assign trial = {rem_q, quo_q[CellW-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign done  = done_q;
	assign quo   = quo_q;
	assign rem   = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != 5'd0) begin
			quo_q <= {quo_q[CellW-2:0], fits};
			rem_q <= fits ? DimW'(trial - {1'b0, dvs_q}) : trial[DimW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 5'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 5'd1);
			if (start) begin
				cnt_q <= 5'(CellW);
			end else if (cnt_q != 5'd0) begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/gse_back.sv =====
module gse_back
	import gse_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  item_t            q_item,
	output back_stat_t       stat,
	input  cfg_t             cfg,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CellW-1:0] out_id,
	output logic [CostW-1:0] out_cost,
	output logic             out_diag,
	output logic             out_empty,
	output logic             out_last
);

	state_t           state_q, state_d;
	logic             map_mem [MapDepth];
	logic             rd_bit_q;
	logic [CellW-1:0] clr_addr_q;
	logic [CellW-1:0] cell_q;
	logic [CellW:0]   ids_q [NbrN];
	logic [NbrN-1:0]  geo_q;
	logic [NbrN-1:0]  raw_q;
	logic [NbrN-1:0]  mask_q;
	logic [3:0]       rd_cnt_q;
	logic             in_grid_q;

	logic             out_valid_q;
	logic [CellW-1:0] out_id_q;
	logic [CostW-1:0] out_cost_q;
	logic             out_diag_q;
	logic             out_empty_q;
	logic             out_last_q;

	logic             div_start;
	logic             div_done;
	logic [CellW-1:0] div_quo;
	logic [DimW-1:0]  div_rem;

	logic             can_load;
	logic             mem_we;
	logic [CellW-1:0] mem_wa;
	logic             mem_wd;
	logic [CellW-1:0] mem_ra;
	logic [NbrN-1:0]  raw_full;
	logic [NbrN-1:0]  ok;
	logic [NbrN-1:0]  pick;
	logic [2:0]       pick_idx;
	logic [CellW:0]   c_ext;
	logic [CellW:0]   h_ext;
	logic             w_ok, n_ok, e_ok, s_ok;

	gse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (q_item.cell_id),
		.divisor  (cfg.height),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		state_d        = state_q;
		stat.pop       = 1'b0;
		stat.clearing  = state_q == ST_CLEAR;
		div_start      = 1'b0;
		mem_we         = 1'b0;
		mem_wa         = q_item.cell_id;
		mem_wd         = q_item.passable;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_addr_q;
				mem_wd = 1'b0;
				if (clr_addr_q == CellW'(MapDepth - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					stat.pop = 1'b1;
					if (q_item.cmd == CMD_WRITE) begin
						mem_we = 1'b1;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				if (!in_grid_q) begin
					state_d = ST_EMPTY;
				end else if (rd_cnt_q == 4'(NbrN)) begin
					state_d = (ok == '0) ? ST_EMPTY : ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (can_load && ((mask_q & ~pick) == '0)) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (can_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign mem_ra = ids_q[rd_cnt_q[2:0]][CellW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_wa] <= mem_wd;
		end
		rd_bit_q <= map_mem[mem_ra];
	end

	// neighbor index order: nw ne se sw w n e s
	assign c_ext = {1'b0, cell_q};
	assign h_ext = (CellW+1)'(cfg.height);
	assign w_ok  = div_quo != '0;
	assign n_ok  = div_rem != '0;
	assign e_ok  = ((CellW+1)'(div_quo) + 1'b1) < (CellW+1)'(cfg.width);
	assign s_ok  = ((DimW+1)'(div_rem) + 1'b1) < (DimW+1)'(cfg.height);

	always_comb begin
		raw_full = raw_q;
		if (rd_cnt_q == 4'(NbrN)) begin
			raw_full[NbrN-1] = geo_q[NbrN-1] && !ids_q[NbrN-1][CellW] && rd_bit_q;
		end
		ok[4] = raw_full[4];
		ok[5] = raw_full[5];
		ok[6] = raw_full[6];
		ok[7] = raw_full[7];
		ok[0] = raw_full[0] && raw_full[5] && raw_full[4];
		ok[1] = raw_full[1] && raw_full[5] && raw_full[6];
		ok[2] = raw_full[2] && raw_full[7] && raw_full[6];
		ok[3] = raw_full[3] && raw_full[7] && raw_full[4];
	end

	always_comb begin
		pick     = '0;
		pick_idx = '0;
		for (int i = NbrN - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick     = '0;
				pick[i]  = 1'b1;
				pick_idx = 3'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			cell_q <= q_item.cell_id;
		end
		if (state_q == ST_CALC) begin
			in_grid_q <= div_quo < CellW'(cfg.width);
			geo_q     <= {s_ok, e_ok, n_ok, w_ok,
			              s_ok && w_ok, s_ok && e_ok, n_ok && e_ok, n_ok && w_ok};
			ids_q[0]  <= c_ext - h_ext - 1'b1;
			ids_q[1]  <= c_ext + h_ext - 1'b1;
			ids_q[2]  <= c_ext + h_ext + 1'b1;
			ids_q[3]  <= c_ext - h_ext + 1'b1;
			ids_q[4]  <= c_ext - h_ext;
			ids_q[5]  <= c_ext - 1'b1;
			ids_q[6]  <= c_ext + h_ext;
			ids_q[7]  <= c_ext + 1'b1;
			raw_q     <= '0;
		end
		if (state_q == ST_READ && rd_cnt_q != 4'd0) begin
			raw_q[rd_cnt_q[2:0] - 3'd1] <= geo_q[rd_cnt_q[2:0] - 3'd1]
				&& !ids_q[rd_cnt_q[2:0] - 3'd1][CellW] && rd_bit_q;
		end
		if (state_q == ST_READ && rd_cnt_q == 4'(NbrN)) begin
			mask_q <= ok;
		end else if (state_q == ST_EMIT && can_load) begin
			mask_q <= mask_q & ~pick;
		end
		if (state_q == ST_EMIT && can_load) begin
			out_id_q    <= ids_q[pick_idx][CellW-1:0];
			out_cost_q  <= pick_idx[2] ? cfg.straight_cost : cfg.diag_cost;
			out_diag_q  <= !pick_idx[2];
			out_empty_q <= 1'b0;
			out_last_q  <= (mask_q & ~pick) == '0;
		end else if (state_q == ST_EMPTY && can_load) begin
			out_id_q    <= '0;
			out_cost_q  <= '0;
			out_diag_q  <= 1'b0;
			out_empty_q <= 1'b1;
			out_last_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			rd_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (state_q == ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 4'd1;
			end else begin
				rd_cnt_q <= '0;
			end
			if ((state_q == ST_EMIT || state_q == ST_EMPTY) && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_id    = out_id_q;
	assign out_cost  = out_cost_q;
	assign out_diag  = out_diag_q;
	assign out_empty = out_empty_q;
	assign out_last  = out_last_q;

endmodule

// ===== hw/rtl/grid_successor_expansion.sv =====
// Eight-neighbor successor expansion on a passability bitmap of up to 65536 cells.
// After reset the map is swept to blocked, one cell a cycle; no item is taken
// during the sweep, configuration writes are. A map write is done as the item
// is taken from the queue. An expansion runs the serial divider that splits the
// cell number into column and row, reads the neighbours through the single map
// read port, then gives one result a cycle while the output is accepted. A
// two-entry queue sits in front, and the output register lets the next item
// start while the last result waits.
module grid_successor_expansion
	import gse_pkg::*;
#(
	parameter int MAX_DIM = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // cell_id, passable, zero pad
	input  logic        s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // neighbour_id, step_cost
	output logic [1:0]  m_axis_tuser,   // is_diagonal, empty_res
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [DimW-1:0]  width_q;
	logic [DimW-1:0]  height_q;
	logic [CostW-1:0] straight_q;
	logic [CostW-1:0] diag_q;
	cfg_t             cfg_eff;
	item_t            in_item;
	item_t            q_item;
	logic             q_valid;
	back_stat_t       stat;

	function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
		if (v == '0) begin
			return DimW'(1);
		end else if (32'(v) > MAX_DIM) begin
			return DimW'(MAX_DIM);
		end
		return v;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= DimW'(256);
			height_q   <= DimW'(256);
			straight_q <= CostW'(256);
			diag_q     <= CostW'(362);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH:    width_q    <= cfg_data[DimW-1:0];
				CFG_HEIGHT:   height_q   <= cfg_data[DimW-1:0];
				CFG_STRAIGHT: straight_q <= cfg_data;
				CFG_DIAG:     diag_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_eff.width         = clamp_dim(width_q);
	assign cfg_eff.height        = clamp_dim(height_q);
	assign cfg_eff.straight_cost = straight_q;
	assign cfg_eff.diag_cost     = diag_q;

	assign in_item.cmd      = cmd_t'(s_axis_tuser);
	assign in_item.cell_id  = s_axis_tdata[15:0];
	assign in_item.passable = s_axis_tdata[16];

	gse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.stat     (stat)
	);

	gse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.stat      (stat),
		.cfg       (cfg_eff),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_id    (m_axis_tdata[15:0]),
		.out_cost  (m_axis_tdata[31:16]),
		.out_diag  (m_axis_tuser[0]),
		.out_empty (m_axis_tuser[1]),
		.out_last  (m_axis_tlast)
	);

endmodule
